// ----- src/dvc_pkg.sv -----
package dvc_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int VALUE_BYTES = 8;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 8 * VALUE_BYTES;
   localparam int LEN_W   = 4;
   localparam int STAT_W  = 3;
   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = KEY_W + VAL_W + LEN_W;

   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [STAT_W-1:0] {
      ST_NEW       = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_MATCH     = 3'd2,
      ST_VIOLATION = 3'd3,
      ST_UNKNOWN   = 3'd4,
      ST_REJECT    = 3'd5
   } status_type;

   localparam logic REQ_DEF = 1'b0;
   localparam logic REQ_USE = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the accepted beat, restart the scan
      logic scan;    // table scan in progress
      logic commit;  // write back and load the result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctrl_status_type;

   // bytes below min(len, VALUE_BYTES) are kept
   function automatic logic [VAL_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [VAL_W-1:0] m;
      m = '0;
      for (int b = 0; b < VALUE_BYTES; b++) begin
         if (len > LEN_W'(b)) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

// ----- src/dvc_ram.sv -----
module dvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dvc_ctrl.sv -----
module dvc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dvc_pkg::ctrl_cmd_type     cmd,
   input  dvc_pkg::ctrl_status_type  stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // result register can take a new beat
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/dvc_datapath.sv -----
module dvc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data,
   input  logic                           req_type,
   input  logic [dvc_pkg::KEY_W-1:0]      req_variable_id,
   input  logic [dvc_pkg::VAL_W-1:0]      req_value_bytes,
   input  logic [dvc_pkg::LEN_W-1:0]      req_value_length,
   output logic [dvc_pkg::STAT_W-1:0]     rsp_status,
   output logic [dvc_pkg::KEY_W-1:0]      rsp_echo_id,
   input  dvc_pkg::ctrl_cmd_type          cmd,
   output dvc_pkg::ctrl_status_type       stat
);

   logic                          enable_ff;
   logic [dvc_pkg::CNT_W-1:0]     used_ff;
   logic [dvc_pkg::CNT_W-1:0]     scan_addr_ff;
   logic                          rd_pending_ff;
   logic [dvc_pkg::IDX_W-1:0]     rd_addr_ff;
   logic                          found_ff;
   logic [dvc_pkg::IDX_W-1:0]     slot_ff;
   logic [dvc_pkg::VAL_W-1:0]     found_val_ff;
   logic [dvc_pkg::LEN_W-1:0]     found_len_ff;

   logic                          req_use_ff;
   logic [dvc_pkg::KEY_W-1:0]     req_id_ff;
   logic [dvc_pkg::VAL_W-1:0]     req_val_ff;
   logic [dvc_pkg::LEN_W-1:0]     req_len_ff;
   logic [dvc_pkg::VAL_W-1:0]     req_mask_ff;

   logic [dvc_pkg::STAT_W-1:0]    rsp_status_ff;
   logic [dvc_pkg::KEY_W-1:0]     rsp_id_ff;

   logic [dvc_pkg::ENTRY_W-1:0]   rd_data;
   logic [dvc_pkg::KEY_W-1:0]     rd_key;
   logic [dvc_pkg::VAL_W-1:0]     rd_val;
   logic [dvc_pkg::LEN_W-1:0]     rd_len;
   logic                          hit_now;
   logic                          issue;
   logic                          full;
   logic                          is_new;
   logic                          ram_we;
   logic [dvc_pkg::IDX_W-1:0]     ram_wr_addr;
   dvc_pkg::status_type           status_in;

   assign rd_key = rd_data[dvc_pkg::ENTRY_W-1 -: dvc_pkg::KEY_W];
   assign rd_val = rd_data[dvc_pkg::LEN_W +: dvc_pkg::VAL_W];
   assign rd_len = rd_data[dvc_pkg::LEN_W-1:0];

   // first matching entry wins, later reads are dropped
   assign hit_now = rd_pending_ff && !found_ff && (rd_key == req_id_ff);
   assign issue   = cmd.scan && enable_ff && !found_ff && !hit_now && (scan_addr_ff < used_ff);

   assign stat.scan_done = !rd_pending_ff
                         && (found_ff || !enable_ff || (scan_addr_ff >= used_ff));

   assign full   = (used_ff == dvc_pkg::DEPTH_COUNT);
   assign is_new = enable_ff && (req_use_ff == dvc_pkg::REQ_DEF) && !found_ff && !full;
   assign ram_we = cmd.commit && enable_ff && (req_use_ff == dvc_pkg::REQ_DEF)
                 && (found_ff || !full);
   assign ram_wr_addr = found_ff ? slot_ff : used_ff[dvc_pkg::IDX_W-1:0];

   always_comb begin
      if (!enable_ff) begin
         status_in = dvc_pkg::ST_REJECT;
      end else if (req_use_ff == dvc_pkg::REQ_DEF) begin
         if (found_ff) begin
            status_in = dvc_pkg::ST_UPDATED;
         end else if (!full) begin
            status_in = dvc_pkg::ST_NEW;
         end else begin
            status_in = dvc_pkg::ST_REJECT;
         end
      end else if (found_ff) begin
         if ((found_len_ff != req_len_ff) || ((found_val_ff & req_mask_ff) != req_val_ff)) begin
            status_in = dvc_pkg::ST_VIOLATION;
         end else begin
            status_in = dvc_pkg::ST_MATCH;
         end
      end else begin
         status_in = dvc_pkg::ST_UNKNOWN;
      end
   end

   dvc_ram #(
      .WIDTH (dvc_pkg::ENTRY_W),
      .DEPTH (dvc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_id_ff, req_val_ff, req_len_ff}),
      .rd_en   (issue),
      .rd_addr (scan_addr_ff[dvc_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         used_ff       <= '0;
         scan_addr_ff  <= '0;
         rd_pending_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
         if (cmd.load) begin
            scan_addr_ff  <= '0;
            rd_pending_ff <= 1'b0;
            found_ff      <= 1'b0;
         end else begin
            rd_pending_ff <= issue;
            if (issue) begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
            end
            if (hit_now) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.commit && is_new) begin
            used_ff <= used_ff + 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_use_ff  <= req_type;
         req_id_ff   <= req_variable_id;
         req_len_ff  <= req_value_length;
         req_mask_ff <= dvc_pkg::byte_mask(req_value_length);
         req_val_ff  <= req_value_bytes & dvc_pkg::byte_mask(req_value_length);
      end
      if (issue) begin
         rd_addr_ff <= scan_addr_ff[dvc_pkg::IDX_W-1:0];
      end
      if (hit_now) begin
         slot_ff      <= rd_addr_ff;
         found_val_ff <= rd_val;
         found_len_ff <= rd_len;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_id_ff     <= req_id_ff;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_echo_id = rsp_id_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= dvc_pkg::DEPTH_COUNT)
      else $error("entry count above table depth");

   a_no_read_after_hit: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> !rd_pending_ff)
      else $error("table read still in flight after a hit");

   a_new_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && is_new) |=> (used_ff == $past(used_ff) + 1'b1))
      else $error("new entry did not advance the entry count");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (scan_addr_ff < dvc_pkg::DEPTH_COUNT))
      else $error("scan address beyond table depth");

endmodule

// ----- src/def_use_value_checker_unit.sv -----
// def-use value checker: one result beat per request beat
// the table scan reads entries through the single read port and stops at the first
//   matching id, after at most the entry count (up to 128); nothing is scanned
//   when the table is empty or the monitor is off
// a new request is taken only once the previous one has committed its result; a
//   stalled result beat holds the next commit
// reset: synchronous, clears the entry count and the enable; table contents are
//   left as is and never read before written, so no clearing pass is needed
module def_use_value_checker_unit (
   input  logic                        clock,
   input  logic                        reset,
   // configuration: monitor enable
   input  logic                        csr_write_enable,
   input  logic                        csr_write_data,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic [dvc_pkg::KEY_W-1:0]   req_variable_id,
   input  logic [dvc_pkg::VAL_W-1:0]   req_value_bytes,
   input  logic [dvc_pkg::LEN_W-1:0]   req_value_length,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dvc_pkg::STAT_W-1:0]  rsp_status,
   output logic [dvc_pkg::KEY_W-1:0]   rsp_echo_id
);

   // command and status between the sequencer and the table datapath
   dvc_pkg::ctrl_cmd_type    cmd;
   dvc_pkg::ctrl_status_type stat;

   // sequencer: idle -> scan -> commit; the result register lets the next
   // request beat in while an earlier result beat is still stalled
   dvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // table memory, pipelined key scan, compare and write back
   dvc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_type         (req_type),
      .req_variable_id  (req_variable_id),
      .req_value_bytes  (req_value_bytes),
      .req_value_length (req_value_length),
      .rsp_status       (rsp_status),
      .rsp_echo_id      (rsp_echo_id),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

// ----- sim/def_use_value_checker_unit_tb.sv -----
`timescale 1ns / 1ps

module def_use_value_checker_unit_tb;

   // run shape
   localparam int POOL_SIZE    = 150;   // more ids than table entries, so the table fills
   localparam int RANDOM_HALF  = 700;   // enabled random beats per half of the run
   localparam int IGNORED_RUN  = 60;    // beats offered while the monitor is off
   localparam int LONG_HOLD    = 400;   // long response hold-off, in cycles
   localparam int HOLD_SPACING = 600;   // request beats between long hold-offs
   localparam int QUIET_LIMIT  = 3000;  // cycles with work outstanding and no beat moving
   localparam int DRAIN_CYCLES = 300;   // beyond the worst scan of 128 entries

   typedef struct {
      logic                       kind;
      logic [dvc_pkg::KEY_W-1:0]  id;
      logic [dvc_pkg::VAL_W-1:0]  bytes;
      logic [dvc_pkg::LEN_W-1:0]  len;
   } watch_event_type;

   typedef struct {
      dvc_pkg::status_type        status;
      logic [dvc_pkg::KEY_W-1:0]  id;
   } verdict_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         csr_write_enable = 1'b0;
   logic                         csr_write_data = 1'b0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_type = dvc_pkg::REQ_DEF;
   logic [dvc_pkg::KEY_W-1:0]    req_variable_id = '0;
   logic [dvc_pkg::VAL_W-1:0]    req_value_bytes = '0;
   logic [dvc_pkg::LEN_W-1:0]    req_value_length = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [dvc_pkg::STAT_W-1:0]   rsp_status;
   logic [dvc_pkg::KEY_W-1:0]    rsp_echo_id;

   def_use_value_checker_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_variable_id  (req_variable_id),
      .req_value_bytes  (req_value_bytes),
      .req_value_length (req_value_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_echo_id      (rsp_echo_id)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // beats waiting to be offered, and verdicts waiting to come back
   watch_event_type pending_events[$];
   verdict_type     expected_verdicts[$];

   int error_count = 0;
   int req_beats   = 0;
   logic req_took  = 1'b0;

   // mirror of the watch table and the enable bit
   logic [dvc_pkg::KEY_W-1:0] mirror_key   [dvc_pkg::TABLE_DEPTH];
   logic [dvc_pkg::VAL_W-1:0] mirror_value [dvc_pkg::TABLE_DEPTH];
   logic [dvc_pkg::LEN_W-1:0] mirror_len   [dvc_pkg::TABLE_DEPTH];
   int                        mirror_used = 0;
   logic                      mirror_enable = 1'b0;

   // last value each id was defined with, as the generator sees it
   logic [dvc_pkg::KEY_W-1:0] id_pool [POOL_SIZE];
   logic [dvc_pkg::VAL_W-1:0] drafted_value [bit [dvc_pkg::KEY_W-1:0]];
   logic [dvc_pkg::LEN_W-1:0] drafted_len   [bit [dvc_pkg::KEY_W-1:0]];

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // bytes that count for a given length: at most VALUE_BYTES of them
   function automatic logic [dvc_pkg::VAL_W-1:0] kept_bytes(
         input logic [dvc_pkg::LEN_W-1:0] len);
      int n;
      n = (int'(len) > dvc_pkg::VALUE_BYTES) ? dvc_pkg::VALUE_BYTES : int'(len);
      if (n >= dvc_pkg::VALUE_BYTES) begin
         return {dvc_pkg::VAL_W{1'b1}};
      end
      return ~({dvc_pkg::VAL_W{1'b1}} << (8 * n));
   endfunction

   // table lookup and update for one accepted event
   function automatic dvc_pkg::status_type judge_event(input watch_event_type ev);
      logic [dvc_pkg::VAL_W-1:0] mask;
      logic [dvc_pkg::VAL_W-1:0] val;
      int                        slot;
      mask = kept_bytes(ev.len);
      val  = ev.bytes & mask;
      slot = -1;
      if (!mirror_enable) begin
         return dvc_pkg::ST_REJECT;
      end
      // lowest matching entry wins
      for (int i = 0; i < mirror_used; i++) begin
         if (slot < 0 && mirror_key[i] == ev.id) begin
            slot = i;
         end
      end
      if (ev.kind == dvc_pkg::REQ_DEF) begin
         if (slot >= 0) begin
            mirror_value[slot] = val;
            mirror_len[slot]   = ev.len;
            return dvc_pkg::ST_UPDATED;
         end
         if (mirror_used >= dvc_pkg::TABLE_DEPTH) begin
            return dvc_pkg::ST_REJECT;   // table full, definition dropped
         end
         mirror_key[mirror_used]   = ev.id;
         mirror_value[mirror_used] = val;
         mirror_len[mirror_used]   = ev.len;
         mirror_used++;
         return dvc_pkg::ST_NEW;
      end
      if (slot < 0) begin
         return dvc_pkg::ST_UNKNOWN;
      end
      if (mirror_len[slot] != ev.len || (mirror_value[slot] & mask) != val) begin
         return dvc_pkg::ST_VIOLATION;
      end
      return dvc_pkg::ST_MATCH;
   endfunction

   task automatic queue_event(input logic kind, input logic [dvc_pkg::KEY_W-1:0] id,
                              input logic [dvc_pkg::VAL_W-1:0] bytes,
                              input logic [dvc_pkg::LEN_W-1:0] len);
      watch_event_type ev;
      ev.kind  = kind;
      ev.id    = id;
      ev.bytes = bytes;
      ev.len   = len;
      pending_events.push_back(ev);
   endtask

   // mostly 1..VALUE_BYTES, now and then anything the field holds
   function automatic logic [dvc_pkg::LEN_W-1:0] draw_length();
      if ($urandom_range(0, 9) == 0) begin
         return dvc_pkg::LEN_W'($urandom_range(0, 15));
      end
      return dvc_pkg::LEN_W'($urandom_range(1, dvc_pkg::VALUE_BYTES));
   endfunction

   // clean little-endian value, or with junk above the length now and then
   function automatic logic [dvc_pkg::VAL_W-1:0] draw_bytes(
         input logic [dvc_pkg::LEN_W-1:0] len);
      logic [dvc_pkg::VAL_W-1:0] raw;
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) begin
         return raw;
      end
      return raw & kept_bytes(len);
   endfunction

   // definitions from the id pool, uses that mostly replay a known definition,
   // some with one byte or the length disturbed, the rest random, now and then with a fresh id
   task automatic queue_random_event();
      watch_event_type ev;
      int              roll;
      int              b;
      roll  = $urandom_range(0, 99);
      ev.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 45) begin
         ev.kind  = dvc_pkg::REQ_DEF;
         ev.len   = draw_length();
         ev.bytes = draw_bytes(ev.len);
         drafted_value[ev.id] = ev.bytes;
         drafted_len[ev.id]   = ev.len;
      end else begin
         ev.kind = dvc_pkg::REQ_USE;
         if (roll < 88 && drafted_len.exists(ev.id)) begin
            ev.len   = drafted_len[ev.id];
            ev.bytes = drafted_value[ev.id];
            if (roll >= 80) begin
               b = $urandom_range(0, dvc_pkg::VALUE_BYTES - 1);
               ev.bytes[8*b +: 8] = ev.bytes[8*b +: 8] ^ 8'($urandom_range(1, 255));
            end else if (roll >= 76) begin
               ev.len = draw_length();
            end
         end else begin
            ev.len   = draw_length();
            ev.bytes = draw_bytes(ev.len);
            if ($urandom_range(0, 3) == 0) begin
               ev.id = $urandom;   // most likely never defined
            end
         end
      end
      pending_events.push_back(ev);
   endtask

   // wait until every beat is in and every verdict is back
   task automatic settle();
      while (pending_events.size() != 0 || expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // enable write, only ever issued while the block is idle
   task automatic set_monitor(input logic on);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      mirror_enable     = on;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : run_test
      for (int i = 0; i < POOL_SIZE; i++) begin
         id_pool[i] = $urandom;
      end
      id_pool[0] = '0;
      id_pool[1] = '1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // monitor still off after reset: everything is rejected
      queue_event(dvc_pkg::REQ_DEF, 32'h0000_0007, 64'h1122_3344_5566_7788, 4'd8);
      queue_event(dvc_pkg::REQ_USE, 32'h0000_0007, 64'h1122_3344_5566_7788, 4'd8);
      settle();
      set_monitor(1'b1);

      // directed: extreme ids and values, every status but reject
      queue_event(dvc_pkg::REQ_DEF, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      queue_event(dvc_pkg::REQ_USE, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      // junk above a one-byte length is masked on store and on compare
      queue_event(dvc_pkg::REQ_DEF, 32'hFFFF_FFFF, 64'hDEAD_BEEF_CAFE_00A5, 4'd1);
      queue_event(dvc_pkg::REQ_USE, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDA5, 4'd1);
      queue_event(dvc_pkg::REQ_USE, 32'hFFFF_FFFF, 64'h0000_0000_0000_00A5, 4'd2);
      queue_event(dvc_pkg::REQ_USE, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 4'd8);
      queue_event(dvc_pkg::REQ_DEF, 32'h0000_0000, 64'h0000_0000_1234_5678, 4'd4);
      queue_event(dvc_pkg::REQ_USE, 32'h0000_0000, 64'h0000_0000_1234_5678, 4'd4);
      queue_event(dvc_pkg::REQ_USE, 32'h0001_2345, 64'h0000_0000_0000_0000, 4'd8);
      // zero length: no bytes kept, only the length compared
      queue_event(dvc_pkg::REQ_DEF, 32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
      queue_event(dvc_pkg::REQ_USE, 32'h0000_0001, 64'h0000_0000_0000_1234, 4'd0);
      queue_event(dvc_pkg::REQ_USE, 32'h0000_0001, 64'h0000_0000_0000_0000, 4'd1);
      // lengths past VALUE_BYTES: stored raw, all bytes kept
      queue_event(dvc_pkg::REQ_DEF, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 4'd15);
      queue_event(dvc_pkg::REQ_USE, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 4'd15);
      queue_event(dvc_pkg::REQ_USE, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 4'd8);
      queue_event(dvc_pkg::REQ_DEF, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 4'd9);
      queue_event(dvc_pkg::REQ_USE, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 4'd9);
      queue_event(dvc_pkg::REQ_USE, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 4'd8);
      queue_event(dvc_pkg::REQ_DEF, 32'hFFFF_FFFF, 64'h0000_0000_0000_0000, 4'd8);
      queue_event(dvc_pkg::REQ_USE, 32'hFFFF_FFFF, 64'h0000_0000_0000_0000, 4'd8);

      // first random half; the table fills somewhere in here
      for (int i = 0; i < RANDOM_HALF; i++) begin
         queue_random_event();
      end
      settle();

      // monitor off mid-run, table must stay as it was
      set_monitor(1'b0);
      for (int i = 0; i < IGNORED_RUN; i++) begin
         queue_random_event();
      end
      settle();
      set_monitor(1'b1);

      for (int i = 0; i < RANDOM_HALF; i++) begin
         queue_random_event();
      end
      settle();

      // catch any stray beat after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("def_use_value_checker_unit_tb: done, clean");
      end else begin
         $display("def_use_value_checker_unit_tb: done, errors");
      end
      $finish;
   end

   // request driver: bursts of beats, random gaps, payload held while stalled
   int gap_left   = 0;
   int burst_left = 1;

   always @(negedge clock) begin : drive_requests
      logic            holding;
      watch_event_type ev;
      holding = req_valid && !req_took;
      if (req_valid && req_took) begin
         void'(pending_events.pop_front());
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!holding) begin
         if (gap_left > 0 || pending_events.size() == 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end
            req_valid <= 1'b0;
         end else begin
            ev = pending_events[0];
            req_valid        <= 1'b1;
            req_type         <= ev.kind;
            req_variable_id  <= ev.id;
            req_value_bytes  <= ev.bytes;
            req_value_length <= ev.len;
            burst_left--;
            if (burst_left <= 0) begin
               // a third of the gaps are empty, giving back-to-back stretches
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               burst_left = $urandom_range(1, 40);
            end
         end
      end
   end

   // response stall: changing styles, plus a long hold-off every so often
   // so the block backs up and stalls its request side
   int              hold_left    = 0;
   int              next_hold_at = 300;
   int              style_left   = 0;
   stall_style_type stall_style  = STALL_NONE;

   always @(negedge clock) begin : drive_response_stall
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (req_beats >= next_hold_at) begin
         hold_left     = LONG_HOLD;
         next_hold_at += HOLD_SPACING;
         rsp_stall    <= 1'b1;
      end else begin
         if (style_left <= 0) begin
            stall_style = stall_style_type'($urandom_range(0, 2));
            style_left  = $urandom_range(20, 200);
         end else begin
            style_left--;
         end
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:     rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // monitor: predict on every accepted request, check every accepted result
   always @(posedge clock) begin : watch_channels
      watch_event_type ev;
      verdict_type     want;
      req_took <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         ev.kind  = req_type;
         ev.id    = req_variable_id;
         ev.bytes = req_value_bytes;
         ev.len   = req_value_length;
         want.status = judge_event(ev);
         want.id     = ev.id;
         expected_verdicts.push_back(want);
         req_beats <= req_beats + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: status %0d id %h",
                                      rsp_status, rsp_echo_id));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("id %h: status %0d, expected %0d (%s)",
                                         want.id, rsp_status, want.status,
                                         want.status.name()));
            end
            if (rsp_echo_id !== want.id) begin
               report_mismatch($sformatf("echo id %h, expected %h", rsp_echo_id, want.id));
            end
         end
      end
   end

   // watchdog: only counts while something is still owed
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (!reset && (pending_events.size() != 0 || expected_verdicts.size() != 0)
          && !(req_valid && !req_stall) && !(rsp_valid && !rsp_stall)) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("def_use_value_checker_unit_tb: done, errors");
            $finish;
         end
      end else begin
         quiet_cycles <= 0;
      end
   end

endmodule

// ----- def_use_value_checker_unit.f -----
src/dvc_pkg.sv
src/dvc_ram.sv
src/dvc_ctrl.sv
src/dvc_datapath.sv
src/def_use_value_checker_unit.sv
sim/def_use_value_checker_unit_tb.sv
